// ----- design/frame_pacing_controller_core_assert.svh -----
// assertion macros shared by the pacing controller
`ifndef FRAME_PACING_CONTROLLER_CORE_ASSERT_SVH
`define FRAME_PACING_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define FPC_ASSERT_IMPLY(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("pacing controller check failed");

// next-cycle implication, sampled on clock, off during reset
`define FPC_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("pacing controller check failed");

`endif

// ----- design/fpc_pkg.sv -----
`default_nettype none
package fpc_pkg;

   localparam int RATE_W  = 10;
   localparam int SKIP_W  = 8;
   localparam int WAIT_W  = 16;
   localparam int TIME_W  = 32;
   localparam int FRAME_W = 32;
   localparam int COUNT_W = 16;
   localparam int DIV_W   = 26;
   localparam int DIV_CNT_W = $clog2(DIV_W);
   localparam int CSR_IDX_W = 2;

   localparam logic [2:0] CMD_UPDATE = 3'd0;
   localparam logic [2:0] CMD_RENDER = 3'd1;
   localparam logic [2:0] CMD_SYNC   = 3'd2;
   localparam logic [2:0] CMD_WAIT   = 3'd3;
   localparam logic [2:0] CMD_PAUSE  = 3'd4;
   localparam logic [2:0] CMD_PLAY   = 3'd5;
   localparam logic [2:0] CMD_STEP   = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_FPS      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SKIP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WAIT = 2'd2;

   localparam logic [RATE_W-1:0]  FPS_RESET      = 10'd60;
   localparam logic [WAIT_W-1:0]  MAX_WAIT_RESET = 16'd500;
   localparam logic [FRAME_W-1:0] FRAME_MAX      = 32'h7FFF_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 16'hFFFF;
   localparam logic [TIME_W-1:0]  MSEC_PER_SEC   = 32'd1000;
   localparam logic [TIME_W-1:0]  FAR_FACTOR     = 32'd10;

   typedef struct packed {
      logic [2:0]        command;
      logic [TIME_W-1:0] now_msec;
   } req_type;

   typedef struct packed {
      logic                      go;
      logic [WAIT_W-1:0]         wait_msec;
      logic signed [FRAME_W-1:0] app_frames;
      logic signed [FRAME_W-1:0] game_frames;
      logic [COUNT_W-1:0]        updates_last_second;
      logic [COUNT_W-1:0]        renders_last_second;
      logic                      paused;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FAR,
      ST_EXEC
   } state_type;

endpackage
`default_nettype wire

// ----- design/fpc_div.sv -----
`default_nettype none
module fpc_div
   import fpc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_W-1:0]   dividend,
   input  wire logic [RATE_W-1:0]  divisor,
   output div_stat_type            stat,
   output logic [DIV_W-1:0]        quotient
);

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [RATE_W-1:0]    rem_ff, rem_in;
   logic [RATE_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [RATE_W:0]      trial;
   logic                 fits;

   // restoring divide, one quotient bit a cycle
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? RATE_W'(trial - {1'b0, dvs_ff}) : trial[RATE_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
`default_nettype wire

// ----- design/frame_pacing_controller_core.sv -----
// frame pacing controller: one request beat carries a command and the current
// millisecond time, and each request gives exactly one response beat with the
// frame counters, the latched per-second counts, the pause flag, a go bit and,
// for wait queries, the milliseconds to the next deadline. update, sync, pause,
// play, step and the unused command go from the request beat through the exec
// state into the response register; render and wait query first start a
// shared restoring divider that works out 1000*updates/rate or 1000/rate one
// quotient bit a cycle, then pass a state that sees it finish and one that
// scales the far-behind bound before the same exec step. one request is in
// work at a time: req_ready is high only while the sequencer is idle, and a
// finished response sits in its output register so the next request can be
// taken while it waits for rsp_ready. csr writes take effect at once; writing
// the frame rate clears the next deadline. a rate of zero is treated as one.
`default_nettype none
`include "frame_pacing_controller_core_assert.svh"
module frame_pacing_controller_core
   import fpc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WAIT_W-1:0]    csr_wdata
);

   // saturating frame counter step, -1 rolls to 0
   function automatic logic [FRAME_W-1:0] frame_inc(input logic [FRAME_W-1:0] c);
      frame_inc = (c == FRAME_MAX) ? c : c + 1'b1;
   endfunction

   // sequencer
   state_type state_ff, state_in;

   // captured request
   logic [2:0]        cmd_ff, cmd_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] far_ff, far_in;

   // configuration
   logic [RATE_W-1:0] fps_ff, fps_in;
   logic [SKIP_W-1:0] max_skip_ff, max_skip_in;
   logic [WAIT_W-1:0] max_wait_ff, max_wait_in;

   // pacing state
   logic [FRAME_W-1:0] app_ff, app_in;
   logic [FRAME_W-1:0] game_ff, game_in;
   logic [COUNT_W-1:0] upd_cnt_ff, upd_cnt_in;
   logic [COUNT_W-1:0] rnd_cnt_ff, rnd_cnt_in;
   logic [COUNT_W-1:0] upd_lat_ff, upd_lat_in;
   logic [COUNT_W-1:0] rnd_lat_ff, rnd_lat_in;
   logic [SKIP_W-1:0]  skip_run_ff, skip_run_in;
   logic               pause_ff, pause_in;
   logic               step_ff, step_in;
   logic [TIME_W-1:0]  win_start_ff, win_start_in;
   logic [TIME_W-1:0]  deadline_ff, deadline_in;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // shared divider
   logic              div_start;
   logic [DIV_W-1:0]  div_dividend;
   logic [RATE_W-1:0] div_divisor;
   logic [DIV_W-1:0]  div_quot;
   div_stat_type      div_stat;

   // datapath terms
   logic [TIME_W-1:0] quot32;
   logic [TIME_W-1:0] elapsed;
   logic [TIME_W-1:0] ahead;
   logic [TIME_W-1:0] behind;
   logic              skip_ok;
   logic              go;
   logic [WAIT_W-1:0] wait_val;
   logic              out_free;

   fpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quot)
   );

   // render uses 1000*updates, wait uses 1000 alone
   assign div_divisor  = (fps_ff == '0) ? RATE_W'(1) : fps_ff;
   assign div_dividend = (req_data.command == CMD_RENDER)
                         ? DIV_W'(upd_cnt_ff) * DIV_W'(MSEC_PER_SEC)
                         : DIV_W'(MSEC_PER_SEC);

   assign quot32   = TIME_W'(div_quot);
   assign elapsed  = now_ff - win_start_ff;
   assign ahead    = deadline_ff - now_ff;
   assign behind   = now_ff - deadline_ff;
   // skip while behind schedule but not ten times behind, and within the run limit
   assign skip_ok  = (elapsed > quot32) && (elapsed < far_ff) && (skip_run_ff < max_skip_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      now_in       = now_ff;
      far_in       = far_ff;
      fps_in       = fps_ff;
      max_skip_in  = max_skip_ff;
      max_wait_in  = max_wait_ff;
      app_in       = app_ff;
      game_in      = game_ff;
      upd_cnt_in   = upd_cnt_ff;
      rnd_cnt_in   = rnd_cnt_ff;
      upd_lat_in   = upd_lat_ff;
      rnd_lat_in   = rnd_lat_ff;
      skip_run_in  = skip_run_ff;
      pause_in     = pause_ff;
      step_in      = step_ff;
      win_start_in = win_start_ff;
      deadline_in  = deadline_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      go           = 1'b0;
      wait_val     = '0;

      // csr writes apply at once; user must issue them only while idle, unchecked
      if (csr_we) begin
         case (csr_index)
            CSR_FPS: begin
               fps_in      = csr_wdata[RATE_W-1:0];
               deadline_in = '0;
            end
            CSR_MAX_SKIP: max_skip_in = csr_wdata[SKIP_W-1:0];
            CSR_MAX_WAIT: max_wait_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_data.command;
               now_in = req_data.now_msec;
               if (req_data.command == CMD_RENDER || req_data.command == CMD_WAIT) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) state_in = ST_FAR;
         end
         ST_FAR: begin
            // ten times the nominal elapsed time
            far_in   = TIME_W'(quot32 * FAR_FACTOR);
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               case (cmd_ff)
                  CMD_UPDATE: begin
                     if (!pause_ff) begin
                        go      = 1'b1;
                        game_in = frame_inc(game_ff);
                        if (step_ff) begin
                           step_in  = 1'b0;
                           pause_in = 1'b1;
                        end
                        if (upd_cnt_ff != COUNT_MAX) upd_cnt_in = upd_cnt_ff + 1'b1;
                     end
                  end
                  CMD_RENDER: begin
                     if (skip_ok) begin
                        skip_run_in = skip_run_ff + 1'b1;
                     end else begin
                        go          = 1'b1;
                        skip_run_in = '0;
                        if (rnd_cnt_ff != COUNT_MAX) rnd_cnt_in = rnd_cnt_ff + 1'b1;
                     end
                  end
                  CMD_SYNC: begin
                     app_in = frame_inc(app_ff);
                     if (elapsed >= MSEC_PER_SEC) begin
                        win_start_in = now_ff;
                        upd_lat_in   = upd_cnt_ff;
                        rnd_lat_in   = rnd_cnt_ff;
                        upd_cnt_in   = '0;
                        rnd_cnt_in   = '0;
                     end
                  end
                  CMD_WAIT: begin
                     if (!ahead[TIME_W-1]) begin
                        if (ahead > TIME_W'(max_wait_ff)) begin
                           // deadline too far ahead: resync
                           deadline_in = now_ff + quot32;
                        end else if (ahead == '0) begin
                           deadline_in = deadline_ff + quot32;
                        end else begin
                           wait_val = ahead[WAIT_W-1:0];
                        end
                     end else if (behind > quot32) begin
                        // missed by more than a frame: resync
                        deadline_in = now_ff + quot32;
                     end else begin
                        deadline_in = deadline_ff + quot32;
                     end
                  end
                  CMD_PAUSE: begin
                     step_in  = 1'b0;
                     pause_in = 1'b1;
                  end
                  CMD_PLAY: begin
                     step_in  = 1'b0;
                     pause_in = 1'b0;
                  end
                  CMD_STEP: begin
                     if (pause_ff) begin
                        pause_in = 1'b0;
                        step_in  = 1'b1;
                     end else begin
                        step_in  = 1'b0;
                        pause_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
               rsp_valid_in                    = 1'b1;
               rsp_data_in.go                  = go;
               rsp_data_in.wait_msec           = wait_val;
               rsp_data_in.app_frames          = $signed(app_in);
               rsp_data_in.game_frames         = $signed(game_in);
               rsp_data_in.updates_last_second = upd_lat_in;
               rsp_data_in.renders_last_second = rnd_lat_in;
               rsp_data_in.paused              = pause_in;
               state_in                        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fps_ff       <= FPS_RESET;
         max_skip_ff  <= '0;
         max_wait_ff  <= MAX_WAIT_RESET;
         app_ff       <= '1;
         game_ff      <= '1;
         upd_cnt_ff   <= '0;
         rnd_cnt_ff   <= '0;
         upd_lat_ff   <= '0;
         rnd_lat_ff   <= '0;
         skip_run_ff  <= '0;
         pause_ff     <= 1'b0;
         step_ff      <= 1'b0;
         win_start_ff <= '0;
         deadline_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fps_ff       <= fps_in;
         max_skip_ff  <= max_skip_in;
         max_wait_ff  <= max_wait_in;
         app_ff       <= app_in;
         game_ff      <= game_in;
         upd_cnt_ff   <= upd_cnt_in;
         rnd_cnt_ff   <= rnd_cnt_in;
         upd_lat_ff   <= upd_lat_in;
         rnd_lat_ff   <= rnd_lat_in;
         skip_run_ff  <= skip_run_in;
         pause_ff     <= pause_in;
         step_ff      <= step_in;
         win_start_ff <= win_start_in;
         deadline_ff  <= deadline_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      now_ff      <= now_in;
      far_ff      <= far_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // divider is never left running while a new request can come in
   `FPC_ASSERT_IMPLY(a_idle_div_quiet, req_ready, !div_stat.busy)
   // the exec step always leaves a response beat behind
   `FPC_ASSERT_NEXT(a_exec_gives_rsp, state_ff == ST_EXEC && out_free, rsp_valid_ff)
   // frame counters only go negative at their starting value of -1
   `FPC_ASSERT_IMPLY(a_game_not_neg, game_ff[FRAME_W-1], game_ff == '1)

endmodule
`default_nettype wire

// ----- bench/tb_frame_pacing_controller_core.sv -----
module tb_frame_pacing_controller_core;
   import fpc_pkg::*;

   // command and register codes that the package leaves unnamed
   localparam logic [2:0]           CMD_UNUSED = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // quiet cycles before the run is declared hung; a render or wait query,
   // divide included, fits well inside, leaving a wide margin for ready stalls
   localparam int WATCHDOG_LIMIT = 2000;
   // cycles to let the block settle once every response is back
   localparam int SETTLE_CYCLES  = 40;
   // updates packed into one window before it is latched
   localparam int LATCH_BURST    = 20;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WAIT_W-1:0] csr_wdata;

   frame_pacing_controller_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // pacing predictor: register copies and timer state
   // ---------------------------------------------------------------------
   logic [RATE_W-1:0]  pace_fps;
   logic [SKIP_W-1:0]  pace_max_skip;
   logic [WAIT_W-1:0]  pace_max_wait;
   logic [FRAME_W-1:0] app_count;
   logic [FRAME_W-1:0] game_count;
   logic [COUNT_W-1:0] upd_count;
   logic [COUNT_W-1:0] draw_count;
   logic [COUNT_W-1:0] upd_latched;
   logic [COUNT_W-1:0] draw_latched;
   logic [SKIP_W-1:0]  skip_run_len;
   logic               hold_flag;
   logic               step_armed;
   logic [TIME_W-1:0]  window_ms;
   logic [TIME_W-1:0]  deadline_ms;

   // responses predicted but not yet seen, oldest first
   rsp_type pending_rsp[$];

   int unsigned error_count   = 0;
   int unsigned events_sent   = 0;
   int unsigned settings_used = 0;
   int unsigned draws_seen    = 0;
   int unsigned skips_seen    = 0;
   int unsigned waits_seen    = 0;
   int unsigned stall_cycles  = 0;

   // no random idling on either side while set
   bit calm = 1'b0;

   // running millisecond clock of the simulated main loop
   logic [TIME_W-1:0] loop_ms = '0;

   // frame counters climb from minus one and stick at the top
   function automatic logic [FRAME_W-1:0] frame_bump(input logic [FRAME_W-1:0] count);
      return (count == FRAME_MAX) ? count : count + 1'b1;
   endfunction

   // work out the response of one accepted beat and advance the timer state
   task automatic pace_predict(input req_type beat);
      rsp_type           resp;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] eff_rate;
      logic [TIME_W-1:0] formal;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] frame_ms;
      logic [TIME_W-1:0] ahead;
      now      = beat.now_msec;
      eff_rate = (pace_fps == '0) ? 32'd1 : TIME_W'(pace_fps);
      resp     = '0;
      case (beat.command)
         CMD_UPDATE: begin
            if (!hold_flag) begin
               game_count = frame_bump(game_count);
               // single step runs one update, then holds again
               if (step_armed) begin
                  step_armed = 1'b0;
                  hold_flag  = 1'b1;
               end
               if (upd_count != COUNT_MAX) upd_count = upd_count + 1'b1;
               resp.go = 1'b1;
            end
         end
         CMD_RENDER: begin
            formal  = (MSEC_PER_SEC * TIME_W'(upd_count)) / eff_rate;
            elapsed = now - window_ms;
            // behind schedule but not hopelessly so, and skip budget left
            if (elapsed > formal && elapsed < formal * FAR_FACTOR &&
                skip_run_len < pace_max_skip) begin
               skip_run_len = skip_run_len + 1'b1;
               skips_seen++;
            end else begin
               skip_run_len = '0;
               if (draw_count != COUNT_MAX) draw_count = draw_count + 1'b1;
               resp.go = 1'b1;
               draws_seen++;
            end
         end
         CMD_SYNC: begin
            app_count = frame_bump(app_count);
            elapsed   = now - window_ms;
            if (elapsed >= MSEC_PER_SEC) begin
               window_ms    = now;
               upd_latched  = upd_count;
               draw_latched = draw_count;
               upd_count    = '0;
               draw_count   = '0;
            end
         end
         CMD_WAIT: begin
            frame_ms = MSEC_PER_SEC / eff_rate;
            ahead    = deadline_ms - now;
            if (!ahead[TIME_W-1]) begin
               if (ahead > TIME_W'(pace_max_wait)) begin
                  deadline_ms = now + frame_ms;
               end else if (ahead == '0) begin
                  deadline_ms = deadline_ms + frame_ms;
               end else begin
                  resp.wait_msec = ahead[WAIT_W-1:0];
                  waits_seen++;
               end
            end else begin
               // deadline already passed, or so far ahead it counts as passed
               elapsed = now - deadline_ms;
               if (elapsed > frame_ms) deadline_ms = now + frame_ms;
               else deadline_ms = deadline_ms + frame_ms;
            end
         end
         CMD_PAUSE: begin
            step_armed = 1'b0;
            hold_flag  = 1'b1;
         end
         CMD_PLAY: begin
            step_armed = 1'b0;
            hold_flag  = 1'b0;
         end
         CMD_STEP: begin
            if (hold_flag) begin
               hold_flag  = 1'b0;
               step_armed = 1'b1;
            end else begin
               step_armed = 1'b0;
               hold_flag  = 1'b1;
            end
         end
         default: begin
            // unused command: state untouched, go stays low
         end
      endcase
      resp.app_frames          = app_count;
      resp.game_frames         = game_count;
      resp.updates_last_second = upd_latched;
      resp.renders_last_second = draw_latched;
      resp.paused              = hold_flag;
      pending_rsp.push_back(resp);
   endtask

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // one request beat; entered and left at a falling edge with valid left
   // high, so back-to-back beats never lower and raise valid in one step
   task automatic send_event(input logic [2:0] cmd, input logic [TIME_W-1:0] at_ms);
      req_type beat;
      beat.command  = cmd;
      beat.now_msec = at_ms;
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pace_predict(beat);
      events_sent++;
      @(negedge clock);
   endtask

   // stop sending and wait for every outstanding response, plus settle time
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register write; only called with the block idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WAIT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_FPS: begin
            pace_fps    = value[RATE_W-1:0];
            deadline_ms = '0;
         end
         CSR_MAX_SKIP: pace_max_skip = value[SKIP_W-1:0];
         CSR_MAX_WAIT: pace_max_wait = value;
         default: begin
            // no register behind this index
         end
      endcase
      @(negedge clock);
   endtask

   // response side drops ready at random, about ten percent of the time, unless calm
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 10);
   end

   // ---------------------------------------------------------------------
   // response checking
   // ---------------------------------------------------------------------
   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h actual %0h", field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response beat with no request waiting for it");
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            compare_field("go", want.go, rsp_data.go);
            compare_field("wait_msec", want.wait_msec, rsp_data.wait_msec);
            compare_field("app_frames", want.app_frames, rsp_data.app_frames);
            compare_field("game_frames", want.game_frames, rsp_data.game_frames);
            compare_field("updates_last_second", want.updates_last_second,
                          rsp_data.updates_last_second);
            compare_field("renders_last_second", want.renders_last_second,
                          rsp_data.renders_last_second);
            compare_field("paused", want.paused, rsp_data.paused);
         end
      end
   end

   // hang detector: counts cycles in which neither channel moves a beat
   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("[frame_pacing_controller_core] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset values: deadline at zero, rate 60, first sync and latch, unused command
   task automatic test_reset_state();
      send_event(CMD_WAIT, 32'd0);
      send_event(CMD_WAIT, 32'd10);
      send_event(CMD_RENDER, 32'd5);
      send_event(CMD_UPDATE, 32'd5);
      send_event(CMD_SYNC, 32'd5);
      send_event(CMD_SYNC, 32'd1000);
      send_event(CMD_UNUSED, 32'd1000);
   endtask

   // pause, play and single step in every order that matters
   task automatic test_pause_step();
      send_event(CMD_PAUSE, 32'd1001);
      send_event(CMD_UPDATE, 32'd1002);
      send_event(CMD_STEP, 32'd1003);
      send_event(CMD_UPDATE, 32'd1004);
      send_event(CMD_UPDATE, 32'd1005);
      send_event(CMD_STEP, 32'd1006);
      send_event(CMD_PLAY, 32'd1007);
      send_event(CMD_STEP, 32'd1008);
      send_event(CMD_PLAY, 32'd1009);
      send_event(CMD_UPDATE, 32'd1010);
   endtask

   // deadlines straddling the half-range point and the 2^32 wrap
   task automatic test_time_wrap();
      send_event(CMD_WAIT, 32'h8000_0000);
      send_event(CMD_WAIT, 32'h7FFF_FFFF);
      send_event(CMD_WAIT, 32'hFFFF_FFFF);
      send_event(CMD_WAIT, 32'hFFFF_FFFA);
      send_event(CMD_SYNC, 32'hFFFF_FFFF);
      send_event(CMD_RENDER, 32'h0000_0010);
   endtask

   // one register setting, then a main loop: mostly well-formed frames
   // (updates, render, sync, wait query) with jittery and sometimes badly
   // lagging time, mixed with pause control and random noise beats
   task automatic run_pacing_phase(input logic [WAIT_W-1:0] fps_word,
                                   input logic [WAIT_W-1:0] skip_word,
                                   input logic [WAIT_W-1:0] wait_word,
                                   input logic [TIME_W-1:0] start_ms,
                                   input int unsigned beats,
                                   input bit no_idle);
      int unsigned first_beat;
      int unsigned period;
      int unsigned roll;
      int unsigned upd_beats;
      logic [2:0]  cmd;
      logic [TIME_W-1:0] at_ms;
      drain_block();
      write_reg(CSR_FPS, fps_word);
      write_reg(CSR_MAX_SKIP, skip_word);
      write_reg(CSR_MAX_WAIT, wait_word);
      settings_used++;
      calm    = no_idle;
      loop_ms = start_ms;
      period  = (pace_fps == '0) ? 1000 : 1000 / pace_fps;
      if (period == 0) period = 1;
      first_beat = events_sent;
      while (events_sent - first_beat < beats) begin
         roll = $urandom_range(99);
         if (roll < 75) begin
            // well-formed frame
            upd_beats = ($urandom_range(9) < 6) ? 1 : $urandom_range(3);
            repeat (upd_beats) send_event(CMD_UPDATE, loop_ms);
            send_event(CMD_RENDER, loop_ms);
            send_event(CMD_SYNC, loop_ms);
            send_event(CMD_WAIT, loop_ms + $urandom_range(period));
            if ($urandom_range(9) == 0) loop_ms += $urandom_range(20 * period);
            else loop_ms += $urandom_range(period / 2, period * 5 / 2);
         end else if (roll < 85) begin
            // pause control, biased toward play so updates keep flowing
            case ($urandom_range(3))
               0:       send_event(CMD_PAUSE, loop_ms);
               1:       send_event(CMD_STEP, loop_ms);
               default: send_event(CMD_PLAY, loop_ms);
            endcase
         end else begin
            // noise: any command code, time near the loop or anywhere
            cmd   = 3'($urandom_range(7));
            at_ms = ($urandom_range(1) == 1) ? $urandom() : loop_ms + $urandom_range(period);
            send_event(cmd, at_ms);
         end
      end
      calm = 1'b0;
   endtask

   // a burst of updates and a render inside a fresh window, then latch them
   task automatic test_count_latch();
      logic [TIME_W-1:0] base_ms;
      drain_block();
      calm    = 1'b1;
      base_ms = window_ms + 32'd2000;
      send_event(CMD_PLAY, base_ms);
      send_event(CMD_SYNC, base_ms);
      repeat (LATCH_BURST) send_event(CMD_UPDATE, base_ms);
      send_event(CMD_RENDER, base_ms);
      send_event(CMD_SYNC, base_ms + MSEC_PER_SEC);
      calm = 1'b0;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;

      // predictor state after reset
      pace_fps      = FPS_RESET;
      pace_max_skip = '0;
      pace_max_wait = MAX_WAIT_RESET;
      app_count     = '1;
      game_count    = '1;
      upd_count     = '0;
      draw_count    = '0;
      upd_latched   = '0;
      draw_latched  = '0;
      skip_run_len  = '0;
      hold_flag     = 1'b0;
      step_armed    = 1'b0;
      window_ms     = '0;
      deadline_ms   = '0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_pause_step();
      test_time_wrap();

      // register sweep: reset-like, top of range, zero rate, slowest rate,
      // all ten rate bits set through a full-width write, then random
      run_pacing_phase(16'd60, 16'd4, 16'd500, 32'd5000, 120, 1'b0);
      run_pacing_phase(16'd1000, 16'd255, 16'd65535, 32'h4000_0000, 120, 1'b1);
      run_pacing_phase(16'd0, 16'd255, 16'd0, 32'hFFFF_FC00, 100, 1'b0);
      run_pacing_phase(16'd1, 16'd1, 16'd1000, 32'hFFFF_F000, 100, 1'b0);
      run_pacing_phase(16'hFFFF, 16'd0, 16'd20, 32'h7FFF_FF00, 100, 1'b0);
      drain_block();
      write_reg(CSR_UNUSED, 16'($urandom()));
      run_pacing_phase(16'($urandom_range(1, 1000)), 16'($urandom_range(255)),
                       16'($urandom()), $urandom(), 150, 1'b0);

      test_count_latch();
      drain_block();

      $display("covered %0d events under %0d register settings, incl. a latched update burst",
               events_sent, settings_used);
      $display("renders drawn %0d, skipped %0d; nonzero waits %0d",
               draws_seen, skips_seen, waits_seen);
      if (error_count == 0) begin
         $display("[frame_pacing_controller_core] OK");
      end else begin
         $display("[frame_pacing_controller_core] ERROR");
      end
      $finish;
   end

endmodule
